[hdl/assert_macros.svh]
// Assertion macros shared by the moving median RTL.
// Needs no other file; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mmm_pkg.sv]
// Shared types and constants of the multichannel moving median.
// No dependencies; imported by every module of the block.
`default_nettype none

package mmm_pkg;

	// Sample and field widths
	localparam int DATA_W = 16;
	localparam int CH_W   = 3;
	localparam int USER_W = 8;
	localparam int CFG_W  = 5;

	// Window length after reset
	localparam logic [CFG_W-1:0] LEN_RESET = 5'd16;

	// Sorter control from the sequencer
	typedef struct packed {
		logic clear;
		logic insert;
	} sort_ctl_t;

endpackage

`default_nettype wire

[hdl/multichannel_moving_median.sv]
// Multichannel moving median filter.
// Input stream: s_tuser[2:0] channel, s_tdata[15:0] pressure sample (Q12.4).
// Output stream: m_tuser[2:0] channel, m_tdata[15:0] median of that window.
// cfg_we/cfg_wdata set the window length (0 acts as 1, above WINDOW saturates);
// write it only while no transaction is in flight.
// Each sample is written to its channel's ring window in the sample RAM, then
// the window is read back one entry a cycle into an insertion sorter and the
// middle entries are picked. The read sweep is followed by the drain, pick-high,
// pick-low and output states before the result is offered, and a new input is
// taken only once the output step is left, so the RAM read sweep sets the pace.
// A channel at or above CHANNELS leaves the windows alone and goes straight to
// the output step, which returns median 0; the next input is taken after it.
// Items are taken one at a time; a new input is accepted while the previous
// result still sits in the output register.
// Reset clears write pointers and per-channel fill counts, so never-written
// entries read as zero; no clearing pass is needed. Length resets to 16.
// When the receiver stalls, the result holds and the next item is processed
// up to its output step, then waits there.
`default_nettype none

module multichannel_moving_median #(
	parameter int WINDOW   = 16,
	parameter int CHANNELS = 5
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       cfg_we,
	input  wire logic [mmm_pkg::CFG_W-1:0]  cfg_wdata,  // window_length
	// input stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [mmm_pkg::DATA_W-1:0] s_tdata,    // [15:0] pressure
	input  wire logic [mmm_pkg::USER_W-1:0] s_tuser,    // [2:0] channel, rest zero
	// output stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [mmm_pkg::DATA_W-1:0] m_tdata,    // [15:0] median
	output logic      [mmm_pkg::USER_W-1:0] m_tuser     // [2:0] result_channel, rest zero
);
	import mmm_pkg::*;

	`include "assert_macros.svh"

	localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int LW    = $clog2(WINDOW + 1);
	localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH = CHANNELS * WINDOW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMPW  = ((LW > CFG_W) ? LW : CFG_W) + 1;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_WRITE   = 7'b0000010,
		ST_READ    = 7'b0000100,
		ST_DRAIN   = 7'b0001000,
		ST_PICK_HI = 7'b0010000,
		ST_PICK_LO = 7'b0100000,
		ST_OUT     = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  cfg_q;
	logic [CH_W-1:0]   ch_q;
	logic [DATA_W-1:0] smp_q;
	logic              bad_q;
	logic [IW-1:0]     wp_q   [CHANNELS];
	logic [LW-1:0]     fill_q [CHANNELS];
	logic [IW-1:0]     rd_idx_q;
	logic              rd_vld_s1;
	logic              rd_zero_s1;
	logic [DATA_W-1:0] hi_q;
	logic [DATA_W-1:0] lo_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic [CH_W-1:0]   m_ch_q;

	logic [LW-1:0]     len_eff;
	logic [CMPW-1:0]   cfg_ext;
	logic [CHW-1:0]    ch_idx;
	logic [LW-1:0]     ptr_ext;
	logic [LW-1:0]     ptr_eff;
	logic [LW-1:0]     ptr_inc;
	logic [LW-1:0]     ptr_next;
	logic [AW-1:0]     base_addr;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic              mem_rd;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic              rd_last;
	logic              out_free;
	logic              s_hs;
	logic [LW-1:0]     mid;
	logic [LW-1:0]     lo_pos;
	logic [IW-1:0]     sel_idx;
	logic [DATA_W-1:0] sel_data;
	logic [DATA_W-1:0] ins_data;
	logic [DATA_W:0]   mid_sum;
	sort_ctl_t         sort_ctl;

	// Effective window length
	assign cfg_ext = CMPW'(cfg_q);
	always_comb begin
		priority if (cfg_q == '0) begin
			len_eff = LW'(1);
		end else if (cfg_ext > CMPW'(WINDOW)) begin
			len_eff = LW'(WINDOW);
		end else begin
			len_eff = LW'(cfg_q);
		end
	end

	// Ring pointer of the current channel
	assign ch_idx    = CHW'(ch_q);
	assign ptr_ext   = LW'(wp_q[ch_idx]);
	assign ptr_eff   = (ptr_ext >= len_eff) ? '0 : ptr_ext;
	assign ptr_inc   = ptr_eff + LW'(1);
	assign ptr_next  = (ptr_inc >= len_eff) ? '0 : ptr_inc;
	assign base_addr = AW'(ch_q) * AW'(WINDOW);

	assign mem_we    = (state_q == ST_WRITE);
	assign mem_waddr = base_addr + AW'(ptr_eff);
	assign mem_rd    = (state_q == ST_READ);
	assign mem_raddr = base_addr + AW'(rd_idx_q);
	assign rd_last   = (LW'(rd_idx_q) == len_eff - LW'(1));

	assign s_tready = (state_q == ST_IDLE);
	assign s_hs     = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= LEN_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_hs) begin
						state_q <= (32'(s_tuser[CH_W-1:0]) < CHANNELS) ? ST_WRITE : ST_OUT;
					end
				end
				ST_WRITE: begin
					rd_idx_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_idx_q <= rd_idx_q + IW'(1);
					if (rd_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:   state_q <= ST_PICK_HI;
				ST_PICK_HI: state_q <= ST_PICK_LO;
				ST_PICK_LO: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Input transaction capture
	always_ff @(posedge clk) begin
		if (s_hs) begin
			ch_q  <= s_tuser[CH_W-1:0];
			smp_q <= s_tdata;
			bad_q <= !(32'(s_tuser[CH_W-1:0]) < CHANNELS);
		end
	end

	// Write pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c]   <= '0;
				fill_q[c] <= '0;
			end
		end else if (mem_we) begin
			wp_q[ch_idx] <= IW'(ptr_next);
			if (ptr_inc > fill_q[ch_idx]) begin
				fill_q[ch_idx] <= ptr_inc;
			end
		end
	end

	// Read tag: valid, and whether the entry was never written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_zero_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= mem_rd;
			rd_zero_s1 <= !(LW'(rd_idx_q) < fill_q[ch_idx]);
		end
	end

	mmm_sample_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(smp_q),
		.rd_en(mem_rd),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Sorter control and middle selection
	assign ins_data        = rd_zero_s1 ? '0 : mem_rdata;
	assign sort_ctl.clear  = (state_q == ST_WRITE);
	assign sort_ctl.insert = rd_vld_s1;
	assign mid             = len_eff >> 1;
	assign lo_pos          = len_eff - LW'(1) - mid;
	assign sel_idx         = (state_q == ST_PICK_HI) ? IW'(mid) : IW'(lo_pos);

	mmm_sorter #(
		.WINDOW(WINDOW),
		.IW    (IW)
	) u_sorter (
		.clk     (clk),
		.ctl     (sort_ctl),
		.ins_data(ins_data),
		.sel_idx (sel_idx),
		.sel_data(sel_data)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_PICK_HI) begin
			hi_q <= sel_data;
		end
		if (state_q == ST_PICK_LO) begin
			lo_q <= sel_data;
		end
	end

	// Output register
	assign mid_sum = {1'b0, hi_q} + {1'b0, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= bad_q ? '0 : mid_sum[DATA_W:1];
			m_ch_q    <= ch_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = USER_W'(m_ch_q);

	// Checks
	`ASSERT_IMPLIES(a_rd_in_len, clk, arst_n, state_q == ST_READ,
		LW'(rd_idx_q) < len_eff, "read sweep ran past the window length")
	`ASSERT_IMPLIES(a_wr_good_ch, clk, arst_n, mem_we,
		32'(ch_q) < CHANNELS, "sample RAM written for an invalid channel")
	`ASSERT_IMPLIES(a_pick_drained, clk, arst_n, state_q == ST_PICK_HI,
		!rd_vld_s1, "median picked before all reads reached the sorter")
	`ASSERT_NEXT(a_wp_in_len, clk, arst_n, state_q == ST_WRITE,
		LW'(wp_q[ch_idx]) < len_eff, "write pointer left the window")

endmodule

`default_nettype wire

[hdl/mmm_sample_ram.sv]
// Simple dual-port sample store: one write and one registered read per cycle.
// Depends on mmm_pkg for the sample width.
`default_nettype none

module mmm_sample_ram #(
	parameter int DEPTH = 80,
	parameter int AW    = 7
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [mmm_pkg::DATA_W-1:0] wdata,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             raddr,
	output logic      [mmm_pkg::DATA_W-1:0] rdata
);
	import mmm_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/mmm_sorter.sv]
// Insertion sorter: keeps the values read so far in ascending order,
// one insertion per cycle. Depends on mmm_pkg for widths and control struct.
`default_nettype none

module mmm_sorter #(
	parameter int WINDOW = 16,
	parameter int IW     = 4
) (
	input  wire logic                       clk,
	input  wire mmm_pkg::sort_ctl_t         ctl,
	input  wire logic [mmm_pkg::DATA_W-1:0] ins_data,
	input  wire logic [IW-1:0]              sel_idx,
	output logic      [mmm_pkg::DATA_W-1:0] sel_data
);
	import mmm_pkg::*;

	// Top bit marks an empty slot, which sorts above every sample
	logic [DATA_W:0] buf_q [WINDOW];
	logic            gt    [WINDOW];
	logic [DATA_W:0] ins_ext;

	assign ins_ext = {1'b0, ins_data};

	// Slots holding a value above the new one shift up by one
	always_comb begin
		for (int j = 0; j < WINDOW; j++) begin
			gt[j] = buf_q[j] > ins_ext;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < WINDOW; j++) begin
			if (ctl.clear) begin
				buf_q[j] <= {1'b1, {DATA_W{1'b0}}};
			end else if (ctl.insert && gt[j]) begin
				if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
					buf_q[j] <= buf_q[(j > 0) ? j - 1 : 0];
				end else begin
					buf_q[j] <= ins_ext;
				end
			end
		end
	end

	assign sel_data = buf_q[sel_idx][DATA_W-1:0];

endmodule

`default_nettype wire
